/* rtl/core/tds_pkg.sv */
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants of the tank drain sequencer.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [15:0] OutletTimeoutRst = 16'd3400;
  localparam logic [15:0] ValveTimeoutRst  = 16'd7200;
  localparam logic [7:0]  SettleTicksRst   = 8'd2;

  typedef enum logic [1:0] {
    REG_OUTLET_TIMEOUT = 2'd0,
    REG_VALVE_TIMEOUT  = 2'd1,
    REG_SETTLE_TICKS   = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_OPEN  = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    PH_READY  = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_DRAIN  = 5'b00100,
    PH_CLOSE  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [15:0] outlet_timeout;
    logic [15:0] valve_timeout;
    logic [7:0]  settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       mode;
    logic       fault;
  } item_t;

  typedef struct packed {
    cmd_e inlet_cmd;
    cmd_e outlet_cmd;
    cmd_e drain_cmd;
    cmd_e vent_cmd;
    logic busy_res;
    logic active_mode;
    logic finished;
  } res_t;

endpackage

/* rtl/core/tds_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tds_cfg_regs
// APB register file holding the drain timeouts and the settle count.
// ----------------------------------------------------------------------------
module tds_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tds_pkg::AddrWidth-1:0]      paddr,
  input  logic [tds_pkg::DataWidth-1:0]      pwdata,
  output logic [tds_pkg::DataWidth-1:0]      prdata,
  output logic                               pready,
  output tds_pkg::cfg_t                      cfg_o
);

  tds_pkg::cfg_t     cfg_q;
  tds_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = tds_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outlet_timeout <= tds_pkg::OutletTimeoutRst;
      cfg_q.valve_timeout  <= tds_pkg::ValveTimeoutRst;
      cfg_q.settle_ticks   <= tds_pkg::SettleTicksRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        tds_pkg::REG_OUTLET_TIMEOUT: cfg_q.outlet_timeout <= pwdata[15:0];
        tds_pkg::REG_VALVE_TIMEOUT:  cfg_q.valve_timeout  <= pwdata[15:0];
        tds_pkg::REG_SETTLE_TICKS:   cfg_q.settle_ticks   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tds_pkg::REG_OUTLET_TIMEOUT: prdata = {16'd0, cfg_q.outlet_timeout};
      tds_pkg::REG_VALVE_TIMEOUT:  prdata = {16'd0, cfg_q.valve_timeout};
      tds_pkg::REG_SETTLE_TICKS:   prdata = {24'd0, cfg_q.settle_ticks};
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/tds_core.sv */
// ----------------------------------------------------------------------------
// tds_core
// Sequencer state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
module tds_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  tds_pkg::item_t  item_i,
  input  tds_pkg::cfg_t   cfg_i,
  output tds_pkg::res_t   res_o
);

  logic             running_q, running_d;
  logic             mode_q, mode_d;
  tds_pkg::phase_e  phase_q, phase_d, phase_mid;
  logic [15:0]      drain_cnt_q, drain_cnt_d;
  logic [7:0]       settle_cnt_q, settle_cnt_d;
  logic             abort;
  logic             is_tick;

  assign is_tick = (item_i.op == tds_pkg::OP_TICK);

  always_comb begin
    abort = running_q
            && ((item_i.op == tds_pkg::OP_STOP) || (is_tick && item_i.fault))
            && ((phase_q == tds_pkg::PH_READY) || (phase_q == tds_pkg::PH_SETTLE)
                || (phase_q == tds_pkg::PH_DRAIN));
    phase_mid = abort ? tds_pkg::PH_CLOSE : phase_q;
  end

  always_comb begin
    running_d          = running_q;
    mode_d             = mode_q;
    phase_d            = phase_q;
    drain_cnt_d        = drain_cnt_q;
    settle_cnt_d       = settle_cnt_q;
    res_o.inlet_cmd    = tds_pkg::CMD_NONE;
    res_o.outlet_cmd   = tds_pkg::CMD_NONE;
    res_o.drain_cmd    = tds_pkg::CMD_NONE;
    res_o.vent_cmd     = tds_pkg::CMD_NONE;
    res_o.finished     = 1'b0;

    if (item_i.op == tds_pkg::OP_START) begin
      running_d = 1'b1;
      mode_d    = item_i.mode;
      phase_d   = tds_pkg::PH_READY;
    end else if (item_i.op == tds_pkg::OP_STOP) begin
      phase_d = phase_mid;
    end else if (is_tick && running_q) begin
      phase_d = phase_mid;
      unique case (phase_mid)
        tds_pkg::PH_READY: begin
          res_o.inlet_cmd  = tds_pkg::CMD_CLOSE;
          res_o.outlet_cmd = tds_pkg::CMD_CLOSE;
          res_o.drain_cmd  = tds_pkg::CMD_CLOSE;
          res_o.vent_cmd   = tds_pkg::CMD_OPEN;
          drain_cnt_d      = mode_q ? cfg_i.valve_timeout : cfg_i.outlet_timeout;
          settle_cnt_d     = cfg_i.settle_ticks;
          phase_d          = tds_pkg::PH_SETTLE;
        end
        tds_pkg::PH_SETTLE: begin
          if (settle_cnt_q != 8'd0) begin
            settle_cnt_d = settle_cnt_q - 8'd1;
          end else begin
            if (mode_q) begin
              res_o.drain_cmd = tds_pkg::CMD_OPEN;
            end else begin
              res_o.outlet_cmd = tds_pkg::CMD_OPEN;
            end
            phase_d = tds_pkg::PH_DRAIN;
          end
        end
        tds_pkg::PH_DRAIN: begin
          res_o.inlet_cmd = tds_pkg::CMD_CLOSE;
          res_o.vent_cmd  = tds_pkg::CMD_OPEN;
          if (mode_q) begin
            res_o.drain_cmd = tds_pkg::CMD_OPEN;
          end else begin
            res_o.drain_cmd  = tds_pkg::CMD_CLOSE;
            res_o.outlet_cmd = tds_pkg::CMD_OPEN;
          end
          if (drain_cnt_q != 16'd0) begin
            drain_cnt_d = drain_cnt_q - 16'd1;
          end else begin
            phase_d = tds_pkg::PH_CLOSE;
          end
        end
        tds_pkg::PH_CLOSE: begin
          res_o.inlet_cmd  = tds_pkg::CMD_CLOSE;
          res_o.outlet_cmd = tds_pkg::CMD_CLOSE;
          res_o.drain_cmd  = tds_pkg::CMD_CLOSE;
          res_o.vent_cmd   = tds_pkg::CMD_OPEN;
          phase_d          = tds_pkg::PH_DONE;
        end
        tds_pkg::PH_DONE: begin
          running_d      = 1'b0;
          res_o.finished = 1'b1;
        end
        default: begin
          phase_d = tds_pkg::PH_READY;
        end
      endcase
    end

    res_o.busy_res    = running_d;
    res_o.active_mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      mode_q       <= 1'b0;
      phase_q      <= tds_pkg::PH_READY;
      drain_cnt_q  <= '0;
      settle_cnt_q <= '0;
    end else if (step_i) begin
      running_q    <= running_d;
      mode_q       <= mode_d;
      phase_q      <= phase_d;
      drain_cnt_q  <= drain_cnt_d;
      settle_cnt_q <= settle_cnt_d;
    end
  end

endmodule

/* rtl/core/tank_drain_sequencer.sv */
// ----------------------------------------------------------------------------
// tank_drain_sequencer
// Five-step tank drain sequencer with valve commands per 100 ms tick.
// ----------------------------------------------------------------------------
// Each input transfer carries an op code (tick, start, stop or no-op), the
// drain mode used on start and the fault flag sampled on a tick. Every input
// transfer produces exactly one output transfer with the four valve
// commands, the busy flag, the latched mode and the finished flag.
// An accepted item is held in an input register, passes the step logic and
// lands in the output register once that register is free. The block
// takes one item per cycle while the receiver does not stall; the only
// loop is the sequencer state, updated in the same cycle as the result.
// When the receiver stalls, the result register holds and the input
// register still takes one further item; after that in_stall_o rises.
// Reset empties both registers, sets the sequencer idle at the ready step and
// loads the default timeouts and settle count. The user must write the three
// registers over the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tank_drain_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic                          mode_i,
  input  logic                          fault_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    inlet_cmd_o,
  output logic [1:0]                    outlet_cmd_o,
  output logic [1:0]                    drain_cmd_o,
  output logic [1:0]                    vent_cmd_o,
  output logic                          busy_res_o,
  output logic                          active_mode_o,
  output logic                          finished_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tds_pkg::AddrWidth-1:0] paddr,
  input  logic [tds_pkg::DataWidth-1:0] pwdata,
  output logic [tds_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  tds_pkg::cfg_t  cfg;
  tds_pkg::item_t item_q;
  tds_pkg::res_t  res_d, res_q;
  logic           s1_valid_q;
  logic           out_valid_q;
  logic           out_free;
  logic           step;
  logic           in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  tds_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tds_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.op    <= op_i;
      item_q.mode  <= mode_i;
      item_q.fault <= fault_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign inlet_cmd_o   = res_q.inlet_cmd;
  assign outlet_cmd_o  = res_q.outlet_cmd;
  assign drain_cmd_o   = res_q.drain_cmd;
  assign vent_cmd_o    = res_q.vent_cmd;
  assign busy_res_o    = res_q.busy_res;
  assign active_mode_o = res_q.active_mode;
  assign finished_o    = res_q.finished;

  a_finish_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> !busy_res_o)
    else $error("finished result still reports busy");

  a_open_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((outlet_cmd_o == tds_pkg::CMD_OPEN)
                    || (drain_cmd_o == tds_pkg::CMD_OPEN)) |-> busy_res_o)
    else $error("outlet path opened while sequence is not busy");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_step_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("processed item did not reach the result register");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the tank drain sequencer.
// ----------------------------------------------------------------------------
// A short table of directed transfers runs first at the reset settings. It
// covers idle ticks, stops and the unused op code, restarts, aborts by stop
// and by fault, and a run through close to done. Random transfers follow over
// several register settings, the extremes among them. A model of the
// sequencer predicts each result, and every output transfer is compared
// field by field with the oldest prediction. Both sides idle in random
// bursts. The receiver holds off once for a long stretch so that the block
// fills up. The registers are read back after each round of writes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned DrainLimit    = 4000;

  localparam logic [2:0] StepReady  = 3'd0;
  localparam logic [2:0] StepSettle = 3'd1;
  localparam logic [2:0] StepDrain  = 3'd2;
  localparam logic [2:0] StepClose  = 3'd3;
  localparam logic [2:0] StepDone   = 3'd4;

  typedef struct {
    tds_pkg::op_e  op;
    logic          mode;
    logic          fault;
    bit            typed;
    tds_pkg::res_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i         = tds_pkg::OP_TICK;
  logic        mode_i       = 1'b0;
  logic        fault_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [1:0]  inlet_cmd_o;
  logic [1:0]  outlet_cmd_o;
  logic [1:0]  drain_cmd_o;
  logic [1:0]  vent_cmd_o;
  logic        busy_res_o;
  logic        active_mode_o;
  logic        finished_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [tds_pkg::AddrWidth-1:0] paddr  = '0;
  logic [tds_pkg::DataWidth-1:0] pwdata = '0;
  logic [tds_pkg::DataWidth-1:0] prdata;
  logic        pready;

  // Model state of the sequencer and its settings.
  tds_pkg::cfg_t cur_cfg;
  bit            seq_running;
  logic          seq_mode;
  logic [2:0]    seq_step;
  logic [15:0]   drain_left;
  logic [7:0]    settle_left;

  tds_pkg::res_t pending_cmds[$];
  int unsigned   mismatch_cnt = 0;
  bit            hold_req     = 1'b0;
  bit            calm         = 1'b0;

  stim_row_t directed_rows [25] = '{
    '{tds_pkg::OP_TICK,  1'b0, 1'b1, 1'b1,
      '{tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE,
        1'b0, 1'b0, 1'b0}},
    '{tds_pkg::OP_STOP,  1'b1, 1'b0, 1'b1,
      '{tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE,
        1'b0, 1'b0, 1'b0}},
    '{tds_pkg::OP_NOP,   1'b1, 1'b1, 1'b1,
      '{tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE,
        1'b0, 1'b0, 1'b0}},
    '{tds_pkg::OP_START, 1'b1, 1'b0, 1'b1,
      '{tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE,
        1'b1, 1'b1, 1'b0}},
    '{tds_pkg::OP_TICK,  1'b0, 1'b0, 1'b1,
      '{tds_pkg::CMD_CLOSE, tds_pkg::CMD_CLOSE, tds_pkg::CMD_CLOSE, tds_pkg::CMD_OPEN,
        1'b1, 1'b1, 1'b0}},
    '{tds_pkg::OP_TICK,  1'b1, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b1, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_NOP,   1'b0, 1'b1, 1'b0, '0},
    '{tds_pkg::OP_STOP,  1'b0, 1'b1, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_STOP,  1'b1, 1'b1, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b1, 1'b1, 1'b0, '0},
    '{tds_pkg::OP_START, 1'b0, 1'b1, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_START, 1'b1, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_START, 1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b1, 1'b1, 1'b0, '0},
    '{tds_pkg::OP_START, 1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_STOP,  1'b0, 1'b0, 1'b0, '0},
    '{tds_pkg::OP_TICK,  1'b1, 1'b0, 1'b0, '0}
  };

  tds_pkg::cfg_t phase_cfgs [NumPhases] = '{
    '{16'd0,     16'd0,     8'd0},
    '{16'hFFFF,  16'hFFFF,  8'hFF},
    '{16'd3,     16'd6,     8'd1},
    '{16'd0,     16'd9,     8'd3},
    '{16'd12,    16'd1,     8'd5},
    '{16'd5,     16'd2,     8'd0}
  };

  tank_drain_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .mode_i        (mode_i),
    .fault_i       (fault_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inlet_cmd_o   (inlet_cmd_o),
    .outlet_cmd_o  (outlet_cmd_o),
    .drain_cmd_o   (drain_cmd_o),
    .vent_cmd_o    (vent_cmd_o),
    .busy_res_o    (busy_res_o),
    .active_mode_o (active_mode_o),
    .finished_o    (finished_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL tank_drain_sequencer");
    $finish;
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic void abort_sequence();
    if (seq_running && seq_step <= StepDrain) seq_step = StepClose;
  endfunction

  function automatic tds_pkg::res_t step_sequencer(tds_pkg::op_e op, logic mode,
                                                   logic fault);
    tds_pkg::res_t r;
    r = '{tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE, tds_pkg::CMD_NONE,
          1'b0, 1'b0, 1'b0};
    if (op == tds_pkg::OP_START) begin
      seq_running = 1'b1;
      seq_mode    = mode;
      seq_step    = StepReady;
    end else if (op == tds_pkg::OP_STOP) begin
      abort_sequence();
    end else if (op == tds_pkg::OP_TICK && seq_running) begin
      if (fault) abort_sequence();
      case (seq_step)
        StepReady: begin
          r.inlet_cmd  = tds_pkg::CMD_CLOSE;
          r.outlet_cmd = tds_pkg::CMD_CLOSE;
          r.drain_cmd  = tds_pkg::CMD_CLOSE;
          r.vent_cmd   = tds_pkg::CMD_OPEN;
          drain_left   = seq_mode ? cur_cfg.valve_timeout : cur_cfg.outlet_timeout;
          settle_left  = cur_cfg.settle_ticks;
          seq_step     = StepSettle;
        end
        StepSettle: begin
          if (settle_left != 8'd0) begin
            settle_left = settle_left - 8'd1;
          end else begin
            if (seq_mode) r.drain_cmd = tds_pkg::CMD_OPEN;
            else r.outlet_cmd = tds_pkg::CMD_OPEN;
            seq_step = StepDrain;
          end
        end
        StepDrain: begin
          r.inlet_cmd = tds_pkg::CMD_CLOSE;
          r.vent_cmd  = tds_pkg::CMD_OPEN;
          if (seq_mode) begin
            r.drain_cmd = tds_pkg::CMD_OPEN;
          end else begin
            r.drain_cmd  = tds_pkg::CMD_CLOSE;
            r.outlet_cmd = tds_pkg::CMD_OPEN;
          end
          if (drain_left != 16'd0) drain_left = drain_left - 16'd1;
          else seq_step = StepClose;
        end
        StepClose: begin
          r.inlet_cmd  = tds_pkg::CMD_CLOSE;
          r.outlet_cmd = tds_pkg::CMD_CLOSE;
          r.drain_cmd  = tds_pkg::CMD_CLOSE;
          r.vent_cmd   = tds_pkg::CMD_OPEN;
          seq_step     = StepDone;
        end
        StepDone: begin
          seq_running = 1'b0;
          r.finished  = 1'b1;
        end
        default: seq_step = StepReady;
      endcase
    end
    r.busy_res    = seq_running;
    r.active_mode = seq_mode;
    return r;
  endfunction

  task automatic send_gap();
    int unsigned n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_item(tds_pkg::op_e op, logic mode, logic fault, bit typed,
                           tds_pkg::res_t want);
    tds_pkg::res_t pred;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i       <= op;
    mode_i     <= mode;
    fault_i    <= fault;
    do @(posedge clk_i); while (in_stall_o);
    pred = step_sequencer(op, mode, fault);
    pending_cmds.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    int unsigned k;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (k = 0; k < DrainLimit && pending_cmds.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(tds_pkg::reg_idx_e idx, logic [tds_pkg::DataWidth-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(tds_pkg::reg_idx_e idx, logic [tds_pkg::DataWidth-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field(idx.name(), want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    tds_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        $error("output transfer with no prediction pending");
        mismatch_cnt++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("inlet_cmd",   32'(want.inlet_cmd),   32'(inlet_cmd_o));
        check_field("outlet_cmd",  32'(want.outlet_cmd),  32'(outlet_cmd_o));
        check_field("drain_cmd",   32'(want.drain_cmd),   32'(drain_cmd_o));
        check_field("vent_cmd",    32'(want.vent_cmd),    32'(vent_cmd_o));
        check_field("busy_res",    32'(want.busy_res),    32'(busy_res_o));
        check_field("active_mode", 32'(want.active_mode), 32'(active_mode_o));
        check_field("finished",    32'(want.finished),    32'(finished_o));
      end
    end
  end

  initial begin
    int unsigned   p;
    int unsigned   i;
    int unsigned   r;
    tds_pkg::op_e  op;
    logic          mode;
    logic          fault;
    tds_pkg::cfg_t c;

    cur_cfg     = '{tds_pkg::OutletTimeoutRst, tds_pkg::ValveTimeoutRst,
                    tds_pkg::SettleTicksRst};
    seq_running = 1'b0;
    seq_mode    = 1'b0;
    seq_step    = StepReady;
    drain_left  = '0;
    settle_left = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    reg_check(tds_pkg::REG_OUTLET_TIMEOUT, {16'd0, tds_pkg::OutletTimeoutRst});
    reg_check(tds_pkg::REG_VALVE_TIMEOUT,  {16'd0, tds_pkg::ValveTimeoutRst});
    reg_check(tds_pkg::REG_SETTLE_TICKS,   {24'd0, tds_pkg::SettleTicksRst});

    foreach (directed_rows[k]) begin
      send_gap();
      send_item(directed_rows[k].op, directed_rows[k].mode, directed_rows[k].fault,
                directed_rows[k].typed, directed_rows[k].want);
    end

    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      c = phase_cfgs[p];
      if (p == 4) begin
        c.outlet_timeout = 16'($urandom_range(0, 20));
        c.valve_timeout  = 16'($urandom_range(0, 20));
        c.settle_ticks   = 8'($urandom_range(0, 6));
      end
      reg_write(tds_pkg::REG_OUTLET_TIMEOUT, {16'($urandom), c.outlet_timeout});
      reg_write(tds_pkg::REG_VALVE_TIMEOUT,  {16'($urandom), c.valve_timeout});
      reg_write(tds_pkg::REG_SETTLE_TICKS,   {24'($urandom), c.settle_ticks});
      cur_cfg = c;
      reg_check(tds_pkg::REG_OUTLET_TIMEOUT, {16'd0, c.outlet_timeout});
      reg_check(tds_pkg::REG_VALVE_TIMEOUT,  {16'd0, c.valve_timeout});
      reg_check(tds_pkg::REG_SETTLE_TICKS,   {24'd0, c.settle_ticks});
      calm = (p == NumPhases - 1);

      for (i = 0; i < ItemsPerPhase; i++) begin
        if (p == 2 && i == 20) hold_req = 1'b1;
        r = $urandom_range(0, 99);
        if ((!seq_running && r < 40) || r < 8) op = tds_pkg::OP_START;
        else if (r < 12) op = tds_pkg::OP_STOP;
        else if (r < 15) op = tds_pkg::OP_NOP;
        else op = tds_pkg::OP_TICK;
        mode = 1'($urandom_range(0, 1));
        if (op == tds_pkg::OP_TICK) fault = ($urandom_range(0, 29) == 0);
        else fault = 1'($urandom_range(0, 1));
        send_gap();
        send_item(op, mode, fault, 1'b0, '0);
      end
    end

    wait_drained();
    if (pending_cmds.size() != 0) begin
      $error("%0d predicted results never arrived", pending_cmds.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("PASS tank_drain_sequencer");
    end else begin
      $display("FAIL tank_drain_sequencer");
    end
    $finish;
  end

endmodule
